[rtl/core/cscE_pkg.sv]
// shared types and constants for the coordinate set combine engine
package csce_pkg;

  localparam int SET_DEPTH_DEF   = 256;
  localparam int STAGE_DEPTH_DEF = 256;
  localparam int COORD_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_COMMIT = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // MODE_APPEND_ALL is internal only: minus or intersect on an empty set
  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_REPLACE    = 3'd1,
    MODE_UNION      = 3'd2,
    MODE_MINUS      = 3'd3,
    MODE_INTERSECT  = 3'd4,
    MODE_APPEND_ALL = 3'd7
  } mode_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic [7:0]         read_index;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] entry_x;
    logic signed [15:0] entry_y;
    logic signed [15:0] entry_z;
    logic               entry_valid;
    logic [8:0]         set_size;
    logic [8:0]         staged_size;
    logic               overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_RD_DONE,
    ST_OUTER_RD,
    ST_INNER_RD,
    ST_INNER_CMP,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_RESULT
  } state_t;

endpackage

[rtl/core/csce_mem.sv]
// single-port-write, single-read memory with registered read data
module csce_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/coordinate_set_combine_engine.sv]
// top level: set and staging memories, commit sequencer and result register
//
// Every item gives one result. A load or clear goes from idle straight to the
// result state; a read passes the read wait and read done states first. A commit
// walks the staging buffer and for each staged coordinate scans the set
// through the single read port of the set memory (union, replace, minus), or
// for each set entry scans the staging buffer (intersect), one compare per
// cycle. Each outer step reads the outer entry, then latches it as the key while
// the first inner entry is read, and each swap removal reads the last set entry
// and writes it into the hole. For minus and intersect an empty set takes the
// staging buffer as is. The block takes no item outside the idle state or
// while the result waits to be taken.
module coordinate_set_combine_engine
  import csce_pkg::*;
#(
  parameter int SET_DEPTH   = SET_DEPTH_DEF,
  parameter int STAGE_DEPTH = STAGE_DEPTH_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0] cfg_data
);

  localparam int SAW = $clog2(SET_DEPTH);
  localparam int TAW = $clog2(STAGE_DEPTH);
  localparam int SCW = $clog2(SET_DEPTH + 1);
  localparam int TCW = $clog2(STAGE_DEPTH + 1);
  localparam int CW  = (SCW > TCW) ? SCW : TCW;
  localparam int VW  = 3 * COORD_BITS;
  localparam logic [SCW-1:0] SET_FULL   = SCW'(SET_DEPTH);
  localparam logic [TCW-1:0] STAGE_FULL = TCW'(STAGE_DEPTH);

  state_t state_r, state_nxt;
  logic [2:0]     mode_r;
  logic [SCW-1:0] set_cnt_r;
  logic [TCW-1:0] stg_cnt_r;
  logic           ovf_r;
  logic [1:0]     op_r;
  logic [7:0]     ridx_r;
  logic [2:0]     cmode_r;   // mode used by the running commit
  logic [CW-1:0]  i_r;       // outer index (staging for union/minus, set for intersect)
  logic [CW-1:0]  j_r;       // inner index
  logic [VW-1:0]  key_r;
  logic [SAW-1:0] hole_r;
  out_item_t      res_r;
  logic           out_valid_r;

  logic           set_we, stg_we;
  logic [SAW-1:0] set_wa, set_ra;
  logic [TAW-1:0] stg_wa, stg_ra;
  logic [VW-1:0]  set_wd, stg_wd, set_rd, stg_rd;

  csce_mem #(.DEPTH(SET_DEPTH), .WIDTH(VW)) u_set (
    .clk(clk), .wr_en(set_we), .wr_addr(set_wa), .wr_data(set_wd),
    .rd_addr(set_ra), .rd_data(set_rd)
  );
  csce_mem #(.DEPTH(STAGE_DEPTH), .WIDTH(VW)) u_stg (
    .clk(clk), .wr_en(stg_we), .wr_addr(stg_wa), .wr_data(stg_wd),
    .rd_addr(stg_ra), .rd_data(stg_rd)
  );

  wire accept = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // intersect scans the staging buffer; union and minus scan the set
  wire is_isect   = (cmode_r == MODE_INTERSECT);
  wire app_mode   = (cmode_r == MODE_UNION) || (cmode_r == MODE_APPEND_ALL);
  wire [CW-1:0]  outer_n = is_isect ? CW'(set_cnt_r) : CW'(stg_cnt_r);
  wire [CW-1:0]  inner_n = is_isect ? CW'(stg_cnt_r) : CW'(set_cnt_r);
  wire [VW-1:0]  inner_v = is_isect ? stg_rd : set_rd;
  wire           hit     = (inner_v == key_r);
  wire           inner_last = (j_r + 1'b1 >= inner_n);
  wire           scan_miss  = (j_r >= inner_n) || (!hit && inner_last);

  function automatic logic [15:0] sx(input logic [COORD_BITS-1:0] v);
    sx = 16'($signed(v));
  endfunction

  // loaded value wraps to the stored coordinate width
  function automatic logic [COORD_BITS-1:0] wrap_c(input logic signed [15:0] v);
    wrap_c = COORD_BITS'(v);
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.operation == OP_READ) state_nxt = ST_RD_WAIT;
          else if (in_data.operation == OP_COMMIT) state_nxt = ST_OUTER_RD;
          else state_nxt = ST_RESULT;
        end
      end
      ST_RD_WAIT:  state_nxt = ST_RD_DONE;
      ST_RD_DONE:  state_nxt = ST_RESULT;
      ST_OUTER_RD: begin
        priority if (cmode_r == MODE_IDLE || i_r >= outer_n) state_nxt = ST_RESULT;
        else state_nxt = ST_INNER_RD;
      end
      ST_INNER_RD: state_nxt = ST_INNER_CMP;
      ST_INNER_CMP: begin
        if (scan_miss) state_nxt = is_isect ? ST_MOVE_RD : ST_OUTER_RD;
        else if (hit) state_nxt = (cmode_r == MODE_MINUS) ? ST_MOVE_RD : ST_OUTER_RD;
        else state_nxt = ST_INNER_CMP;
      end
      ST_MOVE_RD:  state_nxt = ST_MOVE_WR;
      ST_MOVE_WR:  state_nxt = ST_OUTER_RD;
      ST_RESULT:   state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // memory addressing
  always_comb begin
    set_we = 1'b0;
    set_wa = SAW'(set_cnt_r);
    set_wd = key_r;
    stg_we = accept && (in_data.operation == OP_LOAD) && (stg_cnt_r < STAGE_FULL);
    stg_wa = TAW'(stg_cnt_r);
    stg_wd = {wrap_c(in_data.coord_x), wrap_c(in_data.coord_y), wrap_c(in_data.coord_z)};
    set_ra = SAW'(j_r);
    stg_ra = TAW'(j_r);
    unique case (state_r)
      ST_IDLE:    set_ra = SAW'(in_data.read_index);
      ST_RD_WAIT: set_ra = SAW'(ridx_r);
      ST_OUTER_RD: begin
        set_ra = SAW'(i_r);
        stg_ra = TAW'(i_r);
      end
      ST_INNER_CMP: begin
        set_ra = SAW'(j_r + 1'b1);
        stg_ra = TAW'(j_r + 1'b1);
      end
      ST_MOVE_RD: set_ra = SAW'(set_cnt_r - 1'b1);
      ST_MOVE_WR: begin
        set_we = 1'b1;
        set_wa = hole_r;
        set_wd = set_rd;
      end
      default: ;
    endcase
    // union and append-all append when the scan missed and the set has room
    if (state_r == ST_INNER_CMP && scan_miss && app_mode && set_cnt_r < SET_FULL) begin
      set_we = 1'b1;
      set_wa = SAW'(set_cnt_r);
      set_wd = key_r;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_IDLE;
      set_cnt_r   <= '0;
      stg_cnt_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      cmode_r     <= MODE_IDLE;
    end else begin
      state_r <= state_nxt;
      if (accept && in_data.operation == OP_CLEAR) mode_r <= MODE_IDLE;
      else if (cfg_valid) mode_r <= cfg_data;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            op_r   <= in_data.operation;
            ridx_r <= in_data.read_index;
            i_r    <= '0;
            unique case (in_data.operation)
              OP_LOAD: begin
                if (stg_cnt_r < STAGE_FULL) stg_cnt_r <= stg_cnt_r + 1'b1;
                else ovf_r <= 1'b1;
              end
              OP_COMMIT: begin
                unique case (mode_r)
                  MODE_REPLACE: begin
                    set_cnt_r <= '0;
                    cmode_r   <= MODE_UNION;
                  end
                  MODE_UNION: cmode_r <= MODE_UNION;
                  MODE_MINUS, MODE_INTERSECT: begin
                    // empty set takes the buffer as is
                    cmode_r <= (set_cnt_r == '0) ? MODE_APPEND_ALL : mode_r;
                  end
                  default: cmode_r <= MODE_IDLE;
                endcase
              end
              OP_CLEAR: set_cnt_r <= '0;
              default: ;
            endcase
          end
        end
        ST_RD_WAIT: ;
        ST_RD_DONE: begin
          if (int'(ridx_r) < int'(set_cnt_r)) begin
            res_r.entry_x <= sx(set_rd[3*COORD_BITS-1 -: COORD_BITS]);
            res_r.entry_y <= sx(set_rd[2*COORD_BITS-1 -: COORD_BITS]);
            res_r.entry_z <= sx(set_rd[COORD_BITS-1:0]);
            res_r.entry_valid <= 1'b1;
          end else begin
            res_r.entry_x <= '0;
            res_r.entry_y <= '0;
            res_r.entry_z <= '0;
            res_r.entry_valid <= 1'b0;
          end
        end
        ST_OUTER_RD: j_r <= '0;
        ST_INNER_RD: begin
          key_r <= is_isect ? set_rd : stg_rd;
          // append-all skips the scan
          if (cmode_r == MODE_APPEND_ALL) j_r <= inner_n;
        end
        ST_INNER_CMP: begin
          if (scan_miss) begin
            if (app_mode) begin
              if (set_cnt_r < SET_FULL) set_cnt_r <= set_cnt_r + 1'b1;
              else ovf_r <= 1'b1;
              i_r <= i_r + 1'b1;
            end else if (is_isect) begin
              hole_r <= SAW'(i_r);
            end else i_r <= i_r + 1'b1;
          end else if (hit) begin
            if (cmode_r == MODE_MINUS) hole_r <= SAW'(j_r);
            else i_r <= i_r + 1'b1;
          end else j_r <= j_r + 1'b1;
        end
        ST_MOVE_RD: begin
          set_cnt_r <= set_cnt_r - 1'b1;
          if (!is_isect) i_r <= i_r + 1'b1;
        end
        ST_MOVE_WR: ;
        ST_RESULT: begin
          out_valid_r <= 1'b1;
          res_r.overflow <= ovf_r;
          res_r.set_size <= 9'(set_cnt_r);
          res_r.staged_size <= (op_r == OP_COMMIT) ? 9'd0 : 9'(stg_cnt_r);
          if (op_r == OP_COMMIT) stg_cnt_r <= '0;
          if (op_r != OP_READ) begin
            res_r.entry_x <= '0;
            res_r.entry_y <= '0;
            res_r.entry_z <= '0;
            res_r.entry_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/csce_checker.sv]
// port-level checks for the coordinate set combine engine, bound to the top level
module csce_checker
  import csce_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_no_accept_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_valid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.entry_valid |->
      out_data.entry_x == 16'sd0 && out_data.entry_y == 16'sd0 && out_data.entry_z == 16'sd0)
    else $error("entry fields set without valid entry");

  a_sizes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.set_size <= 9'd256 && out_data.staged_size <= 9'd256)
    else $error("size out of range");

endmodule

bind coordinate_set_combine_engine csce_checker u_csce_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
